[hdl/fha_pkg.sv]
// shared types, constants and codes of the first-fit heap allocator
// no dependencies
package fha_pkg;

  localparam int unsigned HEAP_BYTES   = 65536;
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned MAX_SEGMENTS = 64;
  localparam int unsigned ALIGN_LOG2   = 3;
  localparam int unsigned ALIGN_BYTES  = 1 << ALIGN_LOG2;
  localparam int unsigned HEAP_LIMIT   = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
  localparam int unsigned IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W        = $clog2(MAX_SEGMENTS + 1);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_FULL    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FMERGE,
    S_MOVE,
    S_WR_HI,
    S_WR_LO,
    S_APPEND,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [15:0] off;
    logic [15:0] size;
    logic        free;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

[hdl/fha_seg_mem.sv]
// segment table memory, one write and one registered read port
// depends on fha_pkg
module fha_seg_mem (
  input  logic              clk_i,
  input  fha_pkg::mem_req_t req_i,
  output fha_pkg::entry_t   rdata_o
);

  fha_pkg::entry_t mem [fha_pkg::MAX_SEGMENTS];
  fha_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/fha_ctrl.sv]
// sequencer of the allocator: table scan, split, merge, entry moves, append
// depends on fha_pkg, drives fha_seg_mem through a request struct
module fha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [15:0]       request_size_i,
  input  logic [15:0]       address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       granted_address_o,
  output logic [2:0]        status_o,
  output fha_pkg::mem_req_t mem_req_o,
  input  fha_pkg::entry_t   mem_rdata_i
);

  localparam int unsigned IW = fha_pkg::IDX_W;
  localparam int unsigned CW = fha_pkg::CNT_W;

  fha_pkg::state_e  state_q, state_d, mv_next_q, mv_next_d;
  logic             func_q, func_d;
  logic [16:0]      need_q, need_d;
  logic [15:0]      addr_q, addr_d;
  logic [CW-1:0]    cnt_q, cnt_d, rdidx_q, rdidx_d;
  logic [16:0]      bump_q, bump_d;
  logic [IW-1:0]    chk_q, chk_d, hit_q, hit_d;
  logic             pv_q, pv_d, split_q, split_d;
  fha_pkg::entry_t  ent_q, ent_d, prev_q, prev_d, lo_q, lo_d, hi_q, hi_d;
  logic [IW-1:0]    mv_src_q, mv_src_d, mv_last_q, mv_last_d, mv_wa_q, mv_wa_d;
  logic             mv_up_q, mv_up_d, mv_two_q, mv_two_d;
  logic             mv_done_q, mv_done_d, mv_pend_q, mv_pend_d;
  logic [15:0]      res_addr_q, res_addr_d, out_addr_q, out_addr_d;
  fha_pkg::status_e res_st_q, res_st_d, out_st_q, out_st_d;
  logic             out_valid_q, out_valid_d;

  logic             accept, issue, match, found, last, split, nv, mp, mn, out_load;
  logic [16:0]      need_in;
  logic [17:0]      sum_app, msize;
  logic [IW-1:0]    base;
  logic [1:0]       dcnt;
  logic [CW-1:0]    mv_first;
  fha_pkg::entry_t  rd;

  assign rd         = mem_rdata_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == fha_pkg::S_IDLE);
  assign need_in    = ({1'b0, request_size_i} + 17'(fha_pkg::ALIGN_BYTES - 1))
                      & ~17'(fha_pkg::ALIGN_BYTES - 1);
  assign issue      = (rdidx_q < cnt_q);
  assign match      = (func_q == fha_pkg::FUNC_FREE) ?
                      (({1'b0, rd.off} + 17'(fha_pkg::HEADER_BYTES)) == {1'b0, addr_q}) :
                      (rd.free && ({1'b0, rd.size} >= need_q));
  assign found      = pv_q && match;
  assign last       = pv_q && !match && (CW'(chk_q) == cnt_q - CW'(1));
  assign split      = ({2'b0, rd.size} > ({1'b0, need_q} + 18'(fha_pkg::HEADER_BYTES)))
                      && (cnt_q < CW'(fha_pkg::MAX_SEGMENTS));
  assign nv         = (CW'(hit_q) + CW'(1)) < cnt_q;
  assign mp         = (hit_q != '0) && prev_q.free;
  assign mn         = nv && rd.free;
  assign base       = mp ? hit_q - IW'(1) : hit_q;
  assign dcnt       = {1'b0, mp} + {1'b0, mn};
  assign mv_first   = CW'(base) + CW'(1) + CW'(dcnt);
  assign msize      = {2'b0, ent_q.size}
                      + (mp ? {2'b0, prev_q.size} + 18'(fha_pkg::HEADER_BYTES) : 18'd0)
                      + (mn ? {2'b0, rd.size} + 18'(fha_pkg::HEADER_BYTES) : 18'd0);
  assign sum_app    = {1'b0, bump_q} + 18'(fha_pkg::HEADER_BYTES) + {1'b0, need_q};
  assign out_load   = (state_q == fha_pkg::S_RESP) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fha_pkg::S_IDLE: begin
        if (accept) begin
          if (func_i == fha_pkg::FUNC_FREE) begin
            state_d = (address_i == '0 || cnt_q == '0) ? fha_pkg::S_RESP : fha_pkg::S_SCAN;
          end else if (request_size_i == '0) begin
            state_d = fha_pkg::S_RESP;
          end else begin
            state_d = (cnt_q == '0) ? fha_pkg::S_APPEND : fha_pkg::S_SCAN;
          end
        end
      end
      fha_pkg::S_SCAN: begin
        if (found) begin
          if (func_q == fha_pkg::FUNC_FREE) begin
            state_d = fha_pkg::S_FMERGE;
          end else if (split) begin
            state_d = ((CW'(chk_q) + CW'(1)) < cnt_q) ? fha_pkg::S_MOVE : fha_pkg::S_WR_HI;
          end else begin
            state_d = fha_pkg::S_WR_LO;
          end
        end else if (last) begin
          state_d = (func_q == fha_pkg::FUNC_FREE) ? fha_pkg::S_RESP : fha_pkg::S_APPEND;
        end
      end
      fha_pkg::S_FMERGE: begin
        state_d = (dcnt != '0 && mv_first < cnt_q) ? fha_pkg::S_MOVE : fha_pkg::S_RESP;
      end
      fha_pkg::S_MOVE: begin
        if (mv_done_q && mv_pend_q) begin
          state_d = mv_next_q;
        end
      end
      fha_pkg::S_WR_HI:  state_d = fha_pkg::S_WR_LO;
      fha_pkg::S_WR_LO:  state_d = fha_pkg::S_RESP;
      fha_pkg::S_APPEND: state_d = fha_pkg::S_RESP;
      fha_pkg::S_RESP: begin
        if (out_load) begin
          state_d = fha_pkg::S_IDLE;
        end
      end
      default: state_d = fha_pkg::S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    func_d      = func_q;
    need_d      = need_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    bump_d      = bump_q;
    rdidx_d     = rdidx_q;
    chk_d       = chk_q;
    pv_d        = 1'b0;
    hit_d       = hit_q;
    split_d     = split_q;
    ent_d       = ent_q;
    prev_d      = prev_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mv_src_d    = mv_src_q;
    mv_last_d   = mv_last_q;
    mv_wa_d     = mv_wa_q;
    mv_up_d     = mv_up_q;
    mv_two_d    = mv_two_q;
    mv_done_d   = mv_done_q;
    mv_pend_d   = 1'b0;
    mv_next_d   = mv_next_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    out_addr_d  = out_addr_q;
    out_st_d    = out_st_q;
    out_valid_d = out_valid_q;
    mem_req_o   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      fha_pkg::S_IDLE: begin
        if (accept) begin
          func_d     = func_i;
          need_d     = need_in;
          addr_d     = address_i;
          rdidx_d    = '0;
          res_addr_d = '0;
          if (func_i == fha_pkg::FUNC_FREE) begin
            res_st_d = (address_i != '0 && cnt_q == '0) ? fha_pkg::ST_UNKNOWN : fha_pkg::ST_OK;
          end else begin
            res_st_d = (request_size_i == '0) ? fha_pkg::ST_ZERO : fha_pkg::ST_OK;
          end
        end
      end
      fha_pkg::S_SCAN: begin
        if (issue) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = rdidx_q[IW-1:0];
          rdidx_d         = rdidx_q + CW'(1);
          chk_d           = rdidx_q[IW-1:0];
          pv_d            = 1'b1;
        end
        if (found) begin
          hit_d      = chk_q;
          ent_d      = rd;
          split_d    = split;
          lo_d       = '{off: rd.off, size: (split ? need_q[15:0] : rd.size), free: 1'b0};
          hi_d.off   = 16'({1'b0, rd.off} + 17'(fha_pkg::HEADER_BYTES) + need_q);
          hi_d.size  = 16'({1'b0, rd.size} - need_q - 17'(fha_pkg::HEADER_BYTES));
          hi_d.free  = 1'b1;
          res_addr_d = (func_q == fha_pkg::FUNC_FREE) ? 16'd0
                       : 16'({1'b0, rd.off} + 17'(fha_pkg::HEADER_BYTES));
          mv_src_d   = IW'(cnt_q - CW'(1));
          mv_last_d  = chk_q + IW'(1);
          mv_up_d    = 1'b1;
          mv_two_d   = 1'b0;
          mv_done_d  = 1'b0;
          mv_next_d  = fha_pkg::S_WR_HI;
        end else if (pv_q) begin
          prev_d = rd;
          if (last && func_q == fha_pkg::FUNC_FREE) begin
            res_st_d = fha_pkg::ST_UNKNOWN;
          end
        end
      end
      fha_pkg::S_FMERGE: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = base;
        mem_req_o.wdata = '{off: (mp ? prev_q.off : ent_q.off), size: msize[15:0], free: 1'b1};
        cnt_d           = cnt_q - CW'(dcnt);
        mv_src_d        = IW'(mv_first);
        mv_last_d       = IW'(cnt_q - CW'(1));
        mv_up_d         = 1'b0;
        mv_two_d        = (dcnt == 2'd2);
        mv_done_d       = 1'b0;
        mv_next_d       = fha_pkg::S_RESP;
      end
      fha_pkg::S_MOVE: begin
        if (!mv_done_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = mv_src_q;
          mv_pend_d       = 1'b1;
          mv_wa_d         = mv_up_q ? mv_src_q + IW'(1)
                                    : mv_src_q - (mv_two_q ? IW'(2) : IW'(1));
          if (mv_src_q == mv_last_q) begin
            mv_done_d = 1'b1;
          end else begin
            mv_src_d = mv_up_q ? mv_src_q - IW'(1) : mv_src_q + IW'(1);
          end
        end
        if (mv_pend_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = mv_wa_q;
          mem_req_o.wdata = rd;
        end
      end
      fha_pkg::S_WR_HI: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = hit_q + IW'(1);
        mem_req_o.wdata = hi_q;
      end
      fha_pkg::S_WR_LO: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = hit_q;
        mem_req_o.wdata = lo_q;
        if (split_q) begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      fha_pkg::S_APPEND: begin
        if (sum_app > 18'(fha_pkg::HEAP_LIMIT)) begin
          res_st_d = fha_pkg::ST_NOSPACE;
        end else if (cnt_q >= CW'(fha_pkg::MAX_SEGMENTS)) begin
          res_st_d = fha_pkg::ST_FULL;
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = cnt_q[IW-1:0];
          mem_req_o.wdata = '{off: bump_q[15:0], size: need_q[15:0], free: 1'b0};
          cnt_d           = cnt_q + CW'(1);
          bump_d          = sum_app[16:0];
          res_addr_d      = 16'({1'b0, bump_q} + 18'(fha_pkg::HEADER_BYTES));
          res_st_d        = fha_pkg::ST_OK;
        end
      end
      fha_pkg::S_RESP: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_st_d    = res_st_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fha_pkg::S_IDLE;
      cnt_q       <= '0;
      bump_q      <= '0;
      pv_q        <= 1'b0;
      mv_pend_q   <= 1'b0;
      mv_done_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bump_q      <= bump_d;
      pv_q        <= pv_d;
      mv_pend_q   <= mv_pend_d;
      mv_done_q   <= mv_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    need_q     <= need_d;
    addr_q     <= addr_d;
    rdidx_q    <= rdidx_d;
    chk_q      <= chk_d;
    hit_q      <= hit_d;
    split_q    <= split_d;
    ent_q      <= ent_d;
    prev_q     <= prev_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mv_src_q   <= mv_src_d;
    mv_last_q  <= mv_last_d;
    mv_wa_q    <= mv_wa_d;
    mv_up_q    <= mv_up_d;
    mv_two_q   <= mv_two_d;
    mv_next_q  <= mv_next_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    out_addr_q <= out_addr_d;
    out_st_q   <= out_st_d;
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_st_q;

endmodule

[hdl/first_fit_heap_allocator_top.sv]
// channel   direction  fields
// in        sink       func_i, request_size_i, address_i
// out       source     granted_address_o, status_o
//
// one request at a time; the table scan reads one segment entry per cycle
// from the single read port, and a split or merge moves the entries behind
// the hit entry through that port one by one
// zero size, null free and a free on an empty table skip the scan
// reset clears the segment count and bump pointer; no memory clearing pass
// a result waits in the output register; the next request is taken meanwhile
//
// top level of the first-fit heap allocator
// depends on fha_pkg, fha_ctrl, fha_seg_mem
module first_fit_heap_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] granted_address_o,
  output logic [2:0]  status_o
);

  fha_pkg::mem_req_t mem_req;
  fha_pkg::entry_t   mem_rdata;

  fha_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .request_size_i    (request_size_i),
    .address_i         (address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .granted_address_o (granted_address_o),
    .status_o          (status_o),
    .mem_req_o         (mem_req),
    .mem_rdata_i       (mem_rdata)
  );

  fha_seg_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

[hdl/fha_checker.sv]
// port-level checks of the first-fit heap allocator, bound to the top level
// depends on fha_pkg and first_fit_heap_allocator_top
module fha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] granted_address_o,
  input logic [2:0]  status_o
);

  // a stalled result transfer holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(granted_address_o)
                                    && $stable(status_o))
    else $error("result changed while stalled");

  // a granted address only comes with an ok status
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && granted_address_o != '0 |-> status_o == fha_pkg::ST_OK)
    else $error("address granted with failing status");

  // a granted address sits behind at least one header
  a_grant_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && granted_address_o != '0
      |-> granted_address_o >= 16'(fha_pkg::HEADER_BYTES))
    else $error("granted address inside the first header");

  // status codes stay within the defined set
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= 3'(fha_pkg::ST_UNKNOWN))
    else $error("undefined status code");

endmodule

bind first_fit_heap_allocator_top fha_checker u_fha_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .granted_address_o (granted_address_o),
  .status_o          (status_o)
);
